[sv/coefficient_rejection_test_top_defines.svh]
// assertion macros for the coefficient rejection test block
`ifndef COEFFICIENT_REJECTION_TEST_TOP_DEFINES_SVH
`define COEFFICIENT_REJECTION_TEST_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/crt_pkg.sv]
// shared widths, register indexes and types of the coefficient rejection test
`default_nettype none
package crt_pkg;

  localparam int unsigned CoefW   = 24;
  localparam int unsigned RandW   = 24;
  localparam int unsigned GammaW  = 21;
  localparam int unsigned BetaW   = 20;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = GammaW;
  localparam int unsigned InDatW  = 2 * CoefW + RandW;
  localparam int unsigned OutDatW = 8;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgGammaIdx = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgBetaIdx  = 8'd1;

  // register values after reset
  localparam logic [GammaW-1:0] GammaReset = 21'd8192;
  localparam logic [BetaW-1:0]  BetaReset  = 20'd115;

  // verdict of one coefficient
  typedef struct packed {
    logic used;
    logic reject;
  } crt_verdict_t;

endpackage
`default_nettype wire

[sv/crt_cfg_regs.sv]
// configuration registers: gamma and beta bounds
`default_nettype none
module crt_cfg_regs
  import crt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDatW-1:0] cfg_data_i,
  output logic                    cfg_ready_o,
  output logic [GammaW-1:0]       gamma_o,
  output logic [BetaW-1:0]        beta_o
);

  logic [GammaW-1:0] gamma_q, gamma_d;
  logic [BetaW-1:0]  beta_q, beta_d;

  assign cfg_ready_o = 1'b1;

  // register decode
  always_comb begin
    gamma_d = gamma_q;
    beta_d  = beta_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgGammaIdx: gamma_d = cfg_data_i[GammaW-1:0];
        CfgBetaIdx:  beta_d  = cfg_data_i[BetaW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GammaReset;
      beta_q  <= BetaReset;
    end else begin
      gamma_q <= gamma_d;
      beta_q  <= beta_d;
    end
  end

  assign gamma_o = gamma_q;
  assign beta_o  = beta_q;

endmodule
`default_nettype wire

[sv/crt_eval.sv]
// per-coefficient band test and random-word comparison
`default_nettype none
module crt_eval
  import crt_pkg::*;
(
  input  wire logic [GammaW-1:0]       gamma_i,
  input  wire logic [BetaW-1:0]        beta_i,
  input  wire logic signed [CoefW-1:0] coefficient_i,
  input  wire logic signed [CoefW-1:0] partner_value_i,
  input  wire logic [RandW-1:0]        random_word_i,
  output crt_verdict_t                 verdict_o
);

  localparam int unsigned WideW = CoefW + 3;
  localparam int unsigned FMagW = GammaW + 1;
  localparam int unsigned ProdW = RandW + FMagW;

  typedef logic signed [WideW-1:0] wide_t;

  logic [CoefW-1:0] val_mag, part_mag;
  wide_t g_s, be_s, val_s, b_s;
  wide_t g_minus_be, max_vb, max_vbe, diff, diff_abs;
  wide_t t1, t2, t3, t1c, t2c, t3c;
  wide_t f_small, gg_small, f_mid, gg_mid, f_s, gg_s;
  logic  in_pass, over, is_small, f_neg, gg_neg, prod_gt;
  logic [FMagW-1:0] f_mag;
  logic [ProdW-1:0] prod, gg_scaled;

  // magnitudes; the most negative code maps to its unsigned magnitude
  assign val_mag  = coefficient_i[CoefW-1] ? (~coefficient_i + 1'b1) : coefficient_i;
  assign part_mag = partner_value_i[CoefW-1] ? (~partner_value_i + 1'b1) : partner_value_i;

  assign g_s   = wide_t'({{(WideW-GammaW){1'b0}}, gamma_i});
  assign be_s  = wide_t'({{(WideW-BetaW){1'b0}}, beta_i});
  assign val_s = wide_t'({{(WideW-CoefW){1'b0}}, val_mag});
  assign b_s   = wide_t'({{(WideW-CoefW){1'b0}}, part_mag});

  // band classification
  assign g_minus_be = g_s - be_s;
  assign in_pass    = (val_s >= be_s) && (val_s < g_minus_be);
  assign over       = val_s >= g_s;
  assign is_small   = val_s < be_s;

  // small-value branch
  assign max_vb   = (val_s > b_s) ? val_s : b_s;
  assign f_small  = (g_s - max_vb) <<< 1;
  assign gg_small = g_minus_be <<< 1;

  // middle-value branch
  assign diff     = val_s - b_s;
  assign diff_abs = diff[WideW-1] ? -diff : diff;
  assign t1       = g_s - diff_abs;
  assign t2       = g_s - (val_s + b_s);
  assign max_vbe  = (val_s > be_s) ? val_s : be_s;
  assign t3       = g_s - max_vbe;
  assign t1c      = t1[WideW-1] ? '0 : t1;
  assign t2c      = t2[WideW-1] ? '0 : t2;
  assign t3c      = t3[WideW-1] ? '0 : t3;
  assign f_mid    = t1c + t2c;
  assign gg_mid   = t3c <<< 1;

  assign f_s  = is_small ? f_small : f_mid;
  assign gg_s = is_small ? gg_small : gg_mid;

  // r*f against g*2^24; both f and a non-negative g stay below 2^22
  assign f_neg     = f_s[WideW-1];
  assign gg_neg    = gg_s[WideW-1];
  assign f_mag     = f_s[FMagW-1:0];
  assign prod      = ProdW'(random_word_i) * ProdW'(f_mag);
  assign gg_scaled = {gg_s[FMagW-1:0], {RandW{1'b0}}};
  assign prod_gt   = prod > gg_scaled;

  assign verdict_o.used   = !in_pass && !over;
  assign verdict_o.reject = over || (!in_pass && (f_neg || gg_neg || prod_gt));

endmodule
`default_nettype wire

[sv/coefficient_rejection_test_top.sv]
// Coefficient rejection test, top level.
// A word accepted into the input register is judged there and leaves through the result register.
// Throughput: one word per cycle; the input register and the result
// register each advance whenever the stage after them is free.
// Reset clears the sticky reject flag and both valid bits and loads the
// gamma and beta bounds with 8192 and 115.
`default_nettype none
`include "coefficient_rejection_test_top_defines.svh"
module coefficient_rejection_test_top
  import crt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDatW-1:0] cfg_data_i,
  // input stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // tdata: coefficient [23:0], partner_value [47:24], random_word [71:48]
  input  wire logic [InDatW-1:0]  s_axis_tdata,
  input  wire logic               s_axis_tlast,
  // result stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // tdata: random_used [0], reject_so_far [1], zero [7:2]
  output logic [OutDatW-1:0]      m_axis_tdata,
  output logic                    m_axis_tlast
);

  logic [GammaW-1:0] gamma;
  logic [BetaW-1:0]  beta;
  crt_verdict_t      verdict;

  logic s1_valid_q, s1_valid_d;
  logic signed [CoefW-1:0] s1_coef_q, s1_part_q;
  logic [RandW-1:0] s1_rand_q;
  logic s1_last_q;
  logic out_valid_q, out_valid_d;
  logic out_used_q, out_rej_q, out_last_q;
  logic flag_q, flag_d;
  logic in_acc, out_acc, s1_adv, rej_now;

  crt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .gamma_o     (gamma),
    .beta_o      (beta)
  );

  crt_eval u_eval (
    .gamma_i         (gamma),
    .beta_i          (beta),
    .coefficient_i   (s1_coef_q),
    .partner_value_i (s1_part_q),
    .random_word_i   (s1_rand_q),
    .verdict_o       (verdict)
  );

  // handshake and stage advance
  assign out_acc       = out_valid_q && m_axis_tready;
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (out_acc ? 1'b0 : out_valid_q);

  // sticky reject flag, cleared after the last word of a polynomial
  assign rej_now = flag_q || verdict.reject;
  assign flag_d  = s1_adv ? (s1_last_q ? 1'b0 : rej_now) : flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      flag_q      <= flag_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_coef_q <= s_axis_tdata[CoefW-1:0];
      s1_part_q <= s_axis_tdata[2*CoefW-1:CoefW];
      s1_rand_q <= s_axis_tdata[InDatW-1:2*CoefW];
      s1_last_q <= s_axis_tlast;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_used_q <= verdict.used;
      out_rej_q  <= rej_now;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDatW-2){1'b0}}, out_rej_q, out_used_q};
  assign m_axis_tlast  = out_last_q;

  // checks
  `CRT_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready,
                  s1_valid_q && out_valid_q && !m_axis_tready,
                  "input stalled without a full pipeline")
  `CRT_ASSERT_NXT(a_flag_clear, clk_i, rst_ni, s1_adv && s1_last_q, !flag_q,
                  "reject flag not cleared after last word")
  `CRT_ASSERT_NXT(a_flag_sticky, clk_i, rst_ni, flag_q && !(s1_adv && s1_last_q), flag_q,
                  "reject flag dropped inside a polynomial")

endmodule
`default_nettype wire

[dv/coefficient_rejection_checker.sv]
// checker: tracks the bounds, predicts each result word and compares it on arrival
module coefficient_rejection_checker
  import crt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [InDatW-1:0]  in_data_i,
  input  logic               in_last_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [OutDatW-1:0] res_data_i,
  input  logic               res_last_i,
  output int                 mismatch_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one random word scales against 2^24
  localparam longint RandScale = 64'sd16777216;

  typedef struct packed {
    logic random_used;
    logic reject_so_far;
    logic done;
  } result_word_t;

  logic [GammaW-1:0] gamma_q;
  logic [BetaW-1:0]  beta_q;
  logic              sticky_reject;
  result_word_t      verdict_q[$];

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // verdict of one coefficient against the current bounds
  function automatic crt_verdict_t judge_coef(logic [CoefW-1:0] z_bits,
                                              logic [CoefW-1:0] v_bits,
                                              logic [RandW-1:0] r_bits);
    longint       gam, bet, mag, pmag, rnd, f, g2;
    crt_verdict_t vd;
    gam  = longint'(gamma_q);
    bet  = longint'(beta_q);
    mag  = longint'($signed(z_bits));
    pmag = longint'($signed(v_bits));
    rnd  = longint'(r_bits);
    if (mag < 0) mag = -mag;
    if (pmag < 0) pmag = -pmag;
    vd.used   = 1'b0;
    vd.reject = 1'b0;
    if (mag >= bet && mag < gam - bet) begin
      // fast-accept band
      vd.reject = 1'b0;
    end else if (mag >= gam) begin
      vd.reject = 1'b1;
    end else begin
      vd.used = 1'b1;
      if (mag < bet) begin
        f  = 2 * gam - 2 * lmax(mag, pmag);
        g2 = 2 * (gam - bet);
      end else begin
        f = lmax(gam - ((mag > pmag) ? mag - pmag : pmag - mag), 0)
            + lmax(gam - (mag + pmag), 0);
        g2 = 2 * lmax(gam - lmax(mag, bet), 0);
      end
      // negative f rejects whatever the random word is
      vd.reject = (f < 0) || (rnd * f > g2 * RandScale);
    end
    return vd;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count_o++;
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    crt_verdict_t vd;
    result_word_t exp_w;
    if (!rst_ni) begin
      gamma_q          <= GammaReset;
      beta_q           <= BetaReset;
      sticky_reject    <= 1'b0;
      verdict_q.delete();
      pending_o        <= 0;
      mismatch_count_o = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgGammaIdx: gamma_q <= cfg_data_i[GammaW-1:0];
          CfgBetaIdx:  beta_q  <= cfg_data_i[BetaW-1:0];
          default: ;
        endcase
      end
      // result words against the oldest prediction
      if (res_valid_i && res_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result word with none expected", res_data_i, 0);
        end else begin
          exp_w = verdict_q.pop_front();
          if (res_data_i[0] !== exp_w.random_used)
            report_mismatch("random_used", res_data_i[0], exp_w.random_used);
          if (res_data_i[1] !== exp_w.reject_so_far)
            report_mismatch("reject_so_far", res_data_i[1], exp_w.reject_so_far);
          if (res_last_i !== exp_w.done)
            report_mismatch("done (tlast)", res_last_i, exp_w.done);
          if (res_data_i[OutDatW-1:2] !== '0)
            report_mismatch("tdata padding", res_data_i[OutDatW-1:2], 0);
        end
      end
      // predict each accepted coefficient word
      if (in_valid_i && in_ready_i) begin
        vd = judge_coef(in_data_i[CoefW-1:0], in_data_i[2*CoefW-1:CoefW],
                        in_data_i[InDatW-1:2*CoefW]);
        exp_w.random_used   = vd.used;
        exp_w.reject_so_far = sticky_reject | vd.reject;
        exp_w.done          = in_last_i;
        // flag clears once the polynomial ends
        sticky_reject <= in_last_i ? 1'b0 : exp_w.reject_so_far;
        verdict_q.push_back(exp_w);
      end
      pending_o <= verdict_q.size();
    end
  end

endmodule

[dv/coefficient_rejection_test_top_tb.sv]
// testbench top: drives bounds and coefficient words, varies back-pressure, gives the verdict
module coefficient_rejection_test_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crt_pkg::*;

  localparam int StallLimit = 1000;
  localparam int PhaseItems = 92;
  localparam int MaxMag     = 8388608;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDatW-1:0] cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [InDatW-1:0]  s_axis_tdata;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OutDatW-1:0] m_axis_tdata;
  logic               m_axis_tlast;

  int mismatch_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int gamma_now;
  int beta_now;
  int quiet_cycles;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  coefficient_rejection_test_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  coefficient_rejection_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_last_i        (s_axis_tlast),
    .res_valid_i      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_data_i       (m_axis_tdata),
    .res_last_i       (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one coefficient word, with random idle cycles ahead of it
  task automatic send_coef(input int z, input int v,
                           input logic [RandW-1:0] r, input logic last_mark);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, v[CoefW-1:0], z[CoefW-1:0]};
    s_axis_tlast  <= last_mark;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CfgDatW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // new bounds once every outstanding result word is back
  task automatic set_bounds(input int gam, input int bet);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    write_reg(CfgGammaIdx, gam);
    write_reg(CfgBetaIdx, bet);
    cfg_valid_i <= 1'b0;
    gamma_now = gam;
    beta_now  = bet;
  endtask

  function automatic int rand_between(int lo, int hi);
    int a, b;
    a = (lo < 0) ? 0 : ((lo > MaxMag) ? MaxMag : lo);
    b = (hi < 0) ? 0 : ((hi > MaxMag) ? MaxMag : hi);
    return (a <= b) ? $urandom_range(b, a) : $urandom_range(a, b);
  endfunction

  // magnitude aimed at the band edges of the current bounds
  function automatic int pick_magnitude();
    case ($urandom_range(0, 7))
      0: return rand_between(0, MaxMag);
      1: return rand_between(0, beta_now);
      2: return rand_between(beta_now - 2, beta_now + 2);
      3: return rand_between(beta_now, gamma_now - beta_now - 1);
      4, 5: return rand_between(gamma_now - beta_now, gamma_now - 1);
      6: return rand_between(gamma_now - beta_now - 2, gamma_now - beta_now + 2);
      default: return rand_between(gamma_now - 2, gamma_now + 2);
    endcase
  endfunction

  task automatic send_random();
    int             mag, pmag;
    logic [RandW-1:0] rw;
    mag = pick_magnitude();
    case ($urandom_range(0, 3))
      0: pmag = pick_magnitude();
      1: pmag = rand_between(mag - 32, mag + 32);
      2: pmag = rand_between(0, 2 * gamma_now);
      default: pmag = rand_between(0, MaxMag);
    endcase
    case ($urandom_range(0, 5))
      0: rw = '0;
      1: rw = '1;
      default: rw = RandW'($urandom);
    endcase
    send_coef($urandom_range(0, 1) ? -mag : mag, $urandom_range(0, 1) ? -pmag : pmag,
              rw, $urandom_range(0, 7) == 0);
  endtask

  initial begin : stimulus
    int g_pick;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    gamma_now      = GammaReset;
    beta_now       = BetaReset;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // bounds after reset: band edges, field extremes, negative f
    send_coef(0, 0, 24'h000000, 1'b0);
    send_coef(115, 0, 24'h123456, 1'b0);
    send_coef(-8076, 7, 24'h000000, 1'b0);
    send_coef(8077, 8077, 24'hFFFFFF, 1'b0);
    send_coef(8191, 1, 24'h000000, 1'b0);
    send_coef(8192, 0, 24'h000000, 1'b1);
    send_coef(-8388608, 8388607, 24'hFFFFFF, 1'b0);
    send_coef(8388607, -8388608, 24'hFFFFFF, 1'b1);
    send_coef(5, 9000, 24'h000000, 1'b1);
    send_coef(114, -114, 24'h800000, 1'b1);
    send_coef(-1, -1, 24'h000001, 1'b0);
    send_coef(1000, 3, 24'h7FFFFF, 1'b1);
    // beta above gamma: empty fast-accept band, negative g
    set_bounds(100, 200);
    send_coef(0, 0, 24'h000000, 1'b0);
    send_coef(150, 0, 24'h000000, 1'b1);
    send_coef(-99, 50, 24'hFFFFFF, 1'b1);
    // gamma of zero rejects everything
    set_bounds(0, 0);
    send_coef(0, 0, 24'h000000, 1'b1);
    send_coef(-5, 5, 24'hFFFFFF, 1'b1);
    // gamma of 2^20, no margin
    set_bounds(1048576, 0);
    send_coef(1048575, 0, 24'hFFFFFF, 1'b0);
    send_coef(0, 0, 24'h000000, 1'b0);
    send_coef(-1048576, 1048576, 24'h000000, 1'b1);
    // gamma of one, widest margin
    set_bounds(1, 1048575);
    send_coef(0, 0, 24'h000000, 1'b0);
    send_coef(1, 0, 24'h000000, 1'b1);

    // random phases over several bound settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_bounds(1048576, 0);
        1: set_bounds(131072, 1000);
        2: set_bounds(524288, 196);
        3: set_bounds(1000, 1200);
        4: begin
          g_pick = $urandom_range(1, 1048576);
          set_bounds(g_pick, $urandom_range(0, g_pick / 4));
        end
        default: set_bounds(GammaReset, BetaReset);
      endcase
      send_idle_pct  = (ph < 2) ? 19 : ((ph < 4) ? 56 : 0);
      recv_stall_pct = (ph < 2) ? 56 : ((ph < 4) ? 19 : 0);
      repeat (PhaseItems) send_random();
    end

    // drain and settle
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
